@@ rtl/sscp_pkg.sv @@
// ----------------------------------------------------------------------------
// sscp_pkg: shared constants and types for the segment closest-point block
// Field widths, fixed-point constants and the per-lane quotient flags.
// ----------------------------------------------------------------------------
package sscp_pkg;

	localparam int SSCP_COORD_BITS = 12;
	localparam int SSCP_FRAC_BITS  = 8;

	localparam int THR_W     = 52;
	localparam int PT_W      = 20;
	localparam int PARAM_W   = 17;
	localparam int SEP_W     = 21;
	localparam int DIV_STEPS = 17;

	localparam logic [PARAM_W-1:0] ONE_Q16    = PARAM_W'(65536);
	localparam logic [SEP_W-1:0]   SEP_MAX    = SEP_W'(2097151);
	localparam logic [THR_W-1:0]   THR_RESET  = THR_W'(1);

	// Early-out flags of one division lane.
	typedef struct packed {
		logic zero;
		logic one;
	} dflag_t;

endpackage

@@ rtl/segment_segment_closest_points.sv @@
// ----------------------------------------------------------------------------
// segment_segment_closest_points: closest points between two 3D segments
// Dot products, clamped parameters, nearest points and their distance.
// ----------------------------------------------------------------------------
// Pipeline: 7 front stages + 17 division cells + 2 point stages
//   + (COORD_BITS+FRAC_BITS+3) root cells + 1 output stage.
// Throughput: one item per cycle unless out_ready stalls the output; every stage and cell holds one item.
// The chains of division and root cells set the latency, not the rate.
// Reset clears all valid bits and loads the parallel threshold with 1.
// ----------------------------------------------------------------------------
module segment_segment_closest_points
	import sscp_pkg::*;
#(
	parameter int COORD_BITS = SSCP_COORD_BITS,
	parameter int FRAC_BITS  = SSCP_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] a_start_x,
	input  logic signed [COORD_BITS-1:0] a_start_y,
	input  logic signed [COORD_BITS-1:0] a_start_z,
	input  logic signed [COORD_BITS-1:0] a_end_x,
	input  logic signed [COORD_BITS-1:0] a_end_y,
	input  logic signed [COORD_BITS-1:0] a_end_z,
	input  logic signed [COORD_BITS-1:0] b_start_x,
	input  logic signed [COORD_BITS-1:0] b_start_y,
	input  logic signed [COORD_BITS-1:0] b_start_z,
	input  logic signed [COORD_BITS-1:0] b_end_x,
	input  logic signed [COORD_BITS-1:0] b_end_y,
	input  logic signed [COORD_BITS-1:0] b_end_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [PT_W-1:0]       near_a_x,
	output logic signed [PT_W-1:0]       near_a_y,
	output logic signed [PT_W-1:0]       near_a_z,
	output logic signed [PT_W-1:0]       near_b_x,
	output logic signed [PT_W-1:0]       near_b_y,
	output logic signed [PT_W-1:0]       near_b_z,
	output logic        [PARAM_W-1:0]    param_a,
	output logic        [PARAM_W-1:0]    param_b,
	output logic        [SEP_W-1:0]      separation,
	output logic                         parallel_flag,
	input  logic                         cfg_we,
	input  logic        [THR_W-1:0]      cfg_wdata
);

	// Edge vectors and offsets need one extra bit; a dot product of three
	// such terms fits in DW bits and a difference of two products in NW.
	localparam int EW      = COORD_BITS + 1;
	localparam int DW      = 2 * EW + 1;
	localparam int NW      = 2 * DW + 1;
	localparam int GEO_W   = 6 * COORD_BITS + 6 * EW;
	localparam int PW      = COORD_BITS + FRAC_BITS + 1;
	localparam int LW      = COORD_BITS + 20;
	localparam int SHIFT   = 16 - FRAC_BITS;
	localparam int SW      = 2 * PW + 4;
	localparam int ITER    = SW / 2;
	localparam int NDIV    = DIV_STEPS;
	localparam int DSIDE_W = GEO_W + 5;
	localparam int SSIDE_W = 6 * PW + 2 * PARAM_W + 1;

	// ------------------------------------------------------------------
	// Helper functions
	// ------------------------------------------------------------------
	function automatic logic [DW-1:0] dot3(input logic [2:0][EW-1:0] p,
			input logic [2:0][EW-1:0] r);
		logic [DW-1:0] acc;
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			acc = acc + DW'($signed(p[i])) * DW'($signed(r[i]));
		end
		return acc;
	endfunction

	function automatic logic [NW-1:0] magn(input logic [NW-1:0] v);
		return v[NW-1] ? (~v + NW'(1)) : v;
	endfunction

	// start + e*t in Q.16, rounded to FRAC_BITS with halves toward +inf.
	function automatic logic [PW-1:0] point(input logic [COORD_BITS-1:0] s,
			input logic [EW-1:0] e, input logic [PARAM_W-1:0] t);
		logic signed [LW-1:0] v;
		logic signed [LW-1:0] w;
		v = (LW'($signed(s)) <<< 16)
			+ LW'($signed(e)) * LW'($signed({1'b0, t}));
		if (SHIFT > 0) begin
			w = (v + (LW'(1) <<< (SHIFT - 1))) >>> SHIFT;
		end else begin
			w = v;
		end
		return w[PW-1:0];
	endfunction

	function automatic logic [PARAM_W-1:0] param(input dflag_t f,
			input logic [PARAM_W-1:0] q);
		logic [PARAM_W:0] r;
		r = {1'b0, q} + (PARAM_W + 1)'(1);
		if (f.zero) begin
			return '0;
		end else if (f.one) begin
			return ONE_Q16;
		end
		return r[PARAM_W:1];
	endfunction

	function automatic logic [PT_W-1:0] to_pt(input logic [PW-1:0] p);
		logic [PW+PT_W-1:0] ext;
		ext = {{PT_W{p[PW-1]}}, p};
		return ext[PT_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [THR_W-1:0] threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: edge vectors ea, eb and the offset q between start points.
	// ------------------------------------------------------------------
	logic [2:0][COORD_BITS-1:0] as_c, bs_c;
	logic [2:0][EW-1:0]         ea_c, eb_c, qv_c;
	logic                       valid_s1, ready_s1;
	logic [GEO_W-1:0]           geo_s1;
	logic [2:0][EW-1:0]         qv_s1;
	logic                       ready_s2;

	assign as_c = {a_start_z, a_start_y, a_start_x};
	assign bs_c = {b_start_z, b_start_y, b_start_x};
	assign ea_c[0] = EW'(a_end_x) - EW'(a_start_x);
	assign ea_c[1] = EW'(a_end_y) - EW'(a_start_y);
	assign ea_c[2] = EW'(a_end_z) - EW'(a_start_z);
	assign eb_c[0] = EW'(b_end_x) - EW'(b_start_x);
	assign eb_c[1] = EW'(b_end_y) - EW'(b_start_y);
	assign eb_c[2] = EW'(b_end_z) - EW'(b_start_z);
	assign qv_c[0] = EW'(b_start_x) - EW'(a_start_x);
	assign qv_c[1] = EW'(b_start_y) - EW'(a_start_y);
	assign qv_c[2] = EW'(b_start_z) - EW'(a_start_z);

	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			geo_s1 <= {as_c, ea_c, bs_c, eb_c};
			qv_s1  <= qv_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: the five dot products.
	// ------------------------------------------------------------------
	logic [2:0][EW-1:0]         ea_1, eb_1;
	logic                       valid_s2;
	logic [GEO_W-1:0]           geo_s2;
	logic [DW-1:0]              vaa_s2, vbb_s2, vba_s2, vqa_s2, vqb_s2;
	logic                       ready_s3;

	// The geometry vector holds as, ea, bs, eb from the top down.
	assign ea_1 = geo_s1[3*EW+3*COORD_BITS +: 3*EW];
	assign eb_1 = geo_s1[3*EW-1:0];
	assign ready_s2 = !valid_s2 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			geo_s2 <= geo_s1;
			vaa_s2 <= dot3(ea_1, ea_1);
			vbb_s2 <= dot3(eb_1, eb_1);
			vba_s2 <= dot3(ea_1, eb_1);
			vqa_s2 <= dot3(qv_s1, ea_1);
			vqb_s2 <= dot3(qv_s1, eb_1);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: products for the determinant and the two numerators.
	// ------------------------------------------------------------------
	logic             valid_s3;
	logic [GEO_W-1:0] geo_s3;
	logic [NW-1:0]    pbb_s3, pab_s3, p1_s3, p2_s3, p3_s3, p4_s3;
	logic [DW-1:0]    vqa_s3, vba_s3;
	logic             ready_s4;

	assign ready_s3 = !valid_s3 || ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			geo_s3 <= geo_s2;
			pbb_s3 <= NW'($signed(vba_s2)) * NW'($signed(vba_s2));
			pab_s3 <= NW'($signed(vaa_s2)) * NW'($signed(vbb_s2));
			p1_s3  <= NW'($signed(vqb_s2)) * NW'($signed(vba_s2));
			p2_s3  <= NW'($signed(vbb_s2)) * NW'($signed(vqa_s2));
			p3_s3  <= NW'($signed(vaa_s2)) * NW'($signed(vqb_s2));
			p4_s3  <= NW'($signed(vba_s2)) * NW'($signed(vqa_s2));
			vqa_s3 <= vqa_s2;
			vba_s3 <= vba_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: determinant and the unclamped numerators.
	// ------------------------------------------------------------------
	logic             valid_s4;
	logic [GEO_W-1:0] geo_s4;
	logic [NW-1:0]    den_s4, na_s4, nb_s4;
	logic [DW-1:0]    vqa_s4, vba_s4;
	logic             ready_s5;

	assign ready_s4 = !valid_s4 || ready_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			geo_s4 <= geo_s3;
			den_s4 <= pbb_s3 - pab_s3;
			na_s4  <= p1_s3 - p2_s3;
			nb_s4  <= p3_s3 - p4_s3;
			vqa_s4 <= vqa_s3;
			vba_s4 <= vba_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: parallel test against the threshold and choice of the
	// dividend and divisor of each lane. A parallel pair pins ta to zero
	// and takes tb from -vqa / vba.
	// ------------------------------------------------------------------
	logic                   par_c;
	logic                   valid_s5;
	logic [GEO_W-1:0]       geo_s5;
	logic [NW-1:0]          num_a_s5, dvs_a_s5, num_b_s5, dvs_b_s5;
	logic                   par_s5;
	logic                   ready_s6;

	assign par_c = {{THR_W{1'b0}}, magn(den_s4)} < {{NW{1'b0}}, threshold_q};
	assign ready_s5 = !valid_s5 || ready_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (ready_s5) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && valid_s4) begin
			geo_s5   <= geo_s4;
			par_s5   <= par_c;
			num_a_s5 <= par_c ? '0 : na_s4;
			dvs_a_s5 <= den_s4;
			num_b_s5 <= par_c ? (NW'(1'b0) - NW'($signed(vqa_s4))) : nb_s4;
			dvs_b_s5 <= par_c ? NW'($signed(vba_s4)) : den_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: magnitudes and the zero early-out (zero dividend, zero
	// divisor or opposite signs).
	// ------------------------------------------------------------------
	logic             valid_s6;
	logic [GEO_W-1:0] geo_s6;
	logic             par_s6, zero_a_s6, zero_b_s6;
	logic [NW-1:0]    mn_a_s6, md_a_s6, mn_b_s6, md_b_s6;
	logic             ready_s7;

	assign ready_s6 = !valid_s6 || ready_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (ready_s6) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s6 && valid_s5) begin
			geo_s6    <= geo_s5;
			par_s6    <= par_s5;
			zero_a_s6 <= (num_a_s5 == '0) || (dvs_a_s5 == '0)
				|| (num_a_s5[NW-1] != dvs_a_s5[NW-1]);
			zero_b_s6 <= (num_b_s5 == '0) || (dvs_b_s5 == '0)
				|| (num_b_s5[NW-1] != dvs_b_s5[NW-1]);
			mn_a_s6   <= magn(num_a_s5);
			md_a_s6   <= magn(dvs_a_s5);
			mn_b_s6   <= magn(num_b_s5);
			md_b_s6   <= magn(dvs_b_s5);
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: the saturating early-out, when the ratio reaches one.
	// ------------------------------------------------------------------
	logic             valid_s7;
	logic [GEO_W-1:0] geo_s7;
	logic             par_s7;
	dflag_t           fa_s7, fb_s7;
	logic [NW-1:0]    mn_a_s7, md_a_s7, mn_b_s7, md_b_s7;

	logic [NDIV:0]                 dv, dr;
	logic [NDIV:0][NW-1:0]         drem_a, ddvs_a, drem_b, ddvs_b;
	logic [NDIV:0][PARAM_W-1:0]    dquo_a, dquo_b;
	logic [NDIV:0][DSIDE_W-1:0]    dside;

	assign ready_s7 = !valid_s7 || dr[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (ready_s7) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s7 && valid_s6) begin
			geo_s7     <= geo_s6;
			par_s7     <= par_s6;
			fa_s7.zero <= zero_a_s6;
			fa_s7.one  <= mn_a_s6 >= md_a_s6;
			fb_s7.zero <= zero_b_s6;
			fb_s7.one  <= mn_b_s6 >= md_b_s6;
			mn_a_s7    <= mn_a_s6;
			md_a_s7    <= md_a_s6;
			mn_b_s7    <= mn_b_s6;
			md_b_s7    <= md_b_s6;
		end
	end

	// ------------------------------------------------------------------
	// Division chain: one quotient bit per cell for both lanes. The
	// geometry and flags travel alongside in the side vector.
	// ------------------------------------------------------------------
	assign dv[0]     = valid_s7;
	assign drem_a[0] = mn_a_s7;
	assign ddvs_a[0] = md_a_s7;
	assign dquo_a[0] = '0;
	assign drem_b[0] = mn_b_s7;
	assign ddvs_b[0] = md_b_s7;
	assign dquo_b[0] = '0;
	assign dside[0]  = {par_s7, fa_s7, fb_s7, geo_s7};

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		sscp_div_cell #(
			.NW     (NW),
			.QW     (PARAM_W),
			.SIDE_W (DSIDE_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv[k]),
			.in_ready  (dr[k]),
			.rem_a_in  (drem_a[k]),
			.dvs_a_in  (ddvs_a[k]),
			.quo_a_in  (dquo_a[k]),
			.rem_b_in  (drem_b[k]),
			.dvs_b_in  (ddvs_b[k]),
			.quo_b_in  (dquo_b[k]),
			.side_in   (dside[k]),
			.out_valid (dv[k+1]),
			.out_ready (dr[k+1]),
			.rem_a_out (drem_a[k+1]),
			.dvs_a_out (ddvs_a[k+1]),
			.quo_a_out (dquo_a[k+1]),
			.rem_b_out (drem_b[k+1]),
			.dvs_b_out (ddvs_b[k+1]),
			.quo_b_out (dquo_b[k+1]),
			.side_out  (dside[k+1])
		);
	end

	// ------------------------------------------------------------------
	// Stage 8: round the quotients to Q1.16 and place the two points.
	// ------------------------------------------------------------------
	logic                       d_par;
	dflag_t                     d_fa, d_fb;
	logic [GEO_W-1:0]           d_geo;
	logic [2:0][COORD_BITS-1:0] as_d, bs_d;
	logic [2:0][EW-1:0]         ea_d, eb_d;
	logic [PARAM_W-1:0]         ta_c, tb_c;
	logic                       valid_s8, ready_s8;
	logic [2:0][PW-1:0]         pa_s8, pb_s8;
	logic [PARAM_W-1:0]         ta_s8, tb_s8;
	logic                       par_s8;
	logic                       ready_s9;

	assign {d_par, d_fa, d_fb, d_geo} = dside[NDIV];
	assign {as_d, ea_d, bs_d, eb_d}   = d_geo;
	assign ta_c     = param(d_fa, dquo_a[NDIV]);
	assign tb_c     = param(d_fb, dquo_b[NDIV]);
	assign ready_s8 = !valid_s8 || ready_s9;
	assign dr[NDIV] = ready_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (ready_s8) begin
			valid_s8 <= dv[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s8 && dv[NDIV]) begin
			for (int i = 0; i < 3; i++) begin
				pa_s8[i] <= point(as_d[i], ea_d[i], ta_c);
				pb_s8[i] <= point(bs_d[i], eb_d[i], tb_c);
			end
			ta_s8  <= ta_c;
			tb_s8  <= tb_c;
			par_s8 <= d_par;
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: squared distance between the emitted points.
	// ------------------------------------------------------------------
	logic [2:0][SW-1:0]  dd_c, sq_c;
	logic                valid_s9;
	logic [SW-1:0]       sum_s9;
	logic [SSIDE_W-1:0]  side_s9;

	logic [ITER:0]              sv, sr;
	logic [ITER:0][SW-1:0]      snum, sroot;
	logic [ITER:0][SSIDE_W-1:0] sside;

	for (genvar i = 0; i < 3; i++) begin : g_diff
		assign dd_c[i] = SW'($signed(pa_s8[i])) - SW'($signed(pb_s8[i]));
		assign sq_c[i] = dd_c[i] * dd_c[i];
	end

	assign ready_s9 = !valid_s9 || sr[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (ready_s9) begin
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s9 && valid_s8) begin
			sum_s9  <= sq_c[0] + sq_c[1] + sq_c[2];
			side_s9 <= {par_s8, ta_s8, tb_s8, pa_s8, pb_s8};
		end
	end

	// ------------------------------------------------------------------
	// Square root chain: one root bit per cell, most significant first.
	// ------------------------------------------------------------------
	assign sv[0]    = valid_s9;
	assign snum[0]  = sum_s9;
	assign sroot[0] = '0;
	assign sside[0] = side_s9;

	for (genvar k = 0; k < ITER; k++) begin : g_sqrt
		sscp_sqrt_cell #(
			.SW      (SW),
			.BIT_POS (2 * (ITER - 1 - k)),
			.SIDE_W  (SSIDE_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (sv[k]),
			.in_ready  (sr[k]),
			.num_in    (snum[k]),
			.root_in   (sroot[k]),
			.side_in   (sside[k]),
			.out_valid (sv[k+1]),
			.out_ready (sr[k+1]),
			.num_out   (snum[k+1]),
			.root_out  (sroot[k+1]),
			.side_out  (sside[k+1])
		);
	end

	// ------------------------------------------------------------------
	// Stage 10: round the root to nearest, saturate, and hold the item
	// until the consumer takes it.
	// ------------------------------------------------------------------
	logic                s_par;
	logic [PARAM_W-1:0]  s_ta, s_tb;
	logic [2:0][PW-1:0]  s_pa, s_pb;
	logic [SW-1:0]       root_rnd;
	logic                valid_s10, ready_s10;
	logic [2:0][PT_W-1:0] pa_s10, pb_s10;
	logic [PARAM_W-1:0]  ta_s10, tb_s10;
	logic [SEP_W-1:0]    sep_s10;
	logic                par_s10;

	assign {s_par, s_ta, s_tb, s_pa, s_pb} = sside[ITER];
	assign root_rnd  = (snum[ITER] > sroot[ITER]) ? (sroot[ITER] + SW'(1)) : sroot[ITER];
	assign ready_s10 = !valid_s10 || out_ready;
	assign sr[ITER]  = ready_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else if (ready_s10) begin
			valid_s10 <= sv[ITER];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s10 && sv[ITER]) begin
			for (int i = 0; i < 3; i++) begin
				pa_s10[i] <= to_pt(s_pa[i]);
				pb_s10[i] <= to_pt(s_pb[i]);
			end
			ta_s10  <= s_ta;
			tb_s10  <= s_tb;
			par_s10 <= s_par;
			sep_s10 <= (root_rnd > SW'(SEP_MAX)) ? SEP_MAX : root_rnd[SEP_W-1:0];
		end
	end

	assign out_valid     = valid_s10;
	assign near_a_x      = pa_s10[0];
	assign near_a_y      = pa_s10[1];
	assign near_a_z      = pa_s10[2];
	assign near_b_x      = pb_s10[0];
	assign near_b_y      = pb_s10[1];
	assign near_b_z      = pb_s10[2];
	assign param_a       = ta_s10;
	assign param_b       = tb_s10;
	assign separation    = sep_s10;
	assign parallel_flag = par_s10;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_thr_zero_never_parallel: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && ready_s5 && threshold_q == '0) |=> !par_s5)
		else $error("pair flagged parallel with a zero threshold");

	a_param_a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (param_a <= ONE_Q16 && param_b <= ONE_Q16))
		else $error("parameter above one");

	a_parallel_pins_ta: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && parallel_flag) |-> (param_a == '0))
		else $error("parallel item with nonzero param_a");

	a_empty_front_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with an empty first stage");

endmodule

@@ rtl/sscp_div_cell.sv @@
// ----------------------------------------------------------------------------
// sscp_div_cell: one restoring division step for two lanes
// Shifts the remainder, subtracts the divisor when it fits and appends one
// quotient bit, then hands everything to the next cell.
// ----------------------------------------------------------------------------
module sscp_div_cell
	import sscp_pkg::*;
#(
	parameter int NW     = 55,
	parameter int QW     = DIV_STEPS,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [NW-1:0]     rem_a_in,
	input  logic [NW-1:0]     dvs_a_in,
	input  logic [QW-1:0]     quo_a_in,
	input  logic [NW-1:0]     rem_b_in,
	input  logic [NW-1:0]     dvs_b_in,
	input  logic [QW-1:0]     quo_b_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NW-1:0]     rem_a_out,
	output logic [NW-1:0]     dvs_a_out,
	output logic [QW-1:0]     quo_a_out,
	output logic [NW-1:0]     rem_b_out,
	output logic [NW-1:0]     dvs_b_out,
	output logic [QW-1:0]     quo_b_out,
	output logic [SIDE_W-1:0] side_out
);

	logic              valid_q;
	logic [NW-1:0]     rem_a_q, dvs_a_q, rem_b_q, dvs_b_q;
	logic [QW-1:0]     quo_a_q, quo_b_q;
	logic [SIDE_W-1:0] side_q;
	logic [NW:0]       sh_a, sh_b;
	logic              ge_a, ge_b;
	logic [NW:0]       dif_a, dif_b;

	assign in_ready = !valid_q || out_ready;

	assign sh_a  = {rem_a_in, 1'b0};
	assign sh_b  = {rem_b_in, 1'b0};
	assign ge_a  = sh_a >= {1'b0, dvs_a_in};
	assign ge_b  = sh_b >= {1'b0, dvs_b_in};
	assign dif_a = ge_a ? (sh_a - {1'b0, dvs_a_in}) : sh_a;
	assign dif_b = ge_b ? (sh_b - {1'b0, dvs_b_in}) : sh_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_a_q <= dif_a[NW-1:0];
			rem_b_q <= dif_b[NW-1:0];
			dvs_a_q <= dvs_a_in;
			dvs_b_q <= dvs_b_in;
			quo_a_q <= {quo_a_in[QW-2:0], ge_a};
			quo_b_q <= {quo_b_in[QW-2:0], ge_b};
			side_q  <= side_in;
		end
	end

	assign out_valid = valid_q;
	assign rem_a_out = rem_a_q;
	assign dvs_a_out = dvs_a_q;
	assign quo_a_out = quo_a_q;
	assign rem_b_out = rem_b_q;
	assign dvs_b_out = dvs_b_q;
	assign quo_b_out = quo_b_q;
	assign side_out  = side_q;

endmodule

@@ rtl/sscp_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// sscp_sqrt_cell: one step of the digit-by-digit integer square root
// Each cell owns one fixed trial bit and refines the remainder and root.
// ----------------------------------------------------------------------------
module sscp_sqrt_cell
	import sscp_pkg::*;
#(
	parameter int SW      = 46,
	parameter int BIT_POS = 0,
	parameter int SIDE_W  = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SW-1:0]     num_in,
	input  logic [SW-1:0]     root_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SW-1:0]     num_out,
	output logic [SW-1:0]     root_out,
	output logic [SIDE_W-1:0] side_out
);

	localparam logic [SW-1:0] BIT_V = SW'(1) << BIT_POS;

	logic              valid_q;
	logic [SW-1:0]     num_q, root_q;
	logic [SIDE_W-1:0] side_q;
	logic [SW-1:0]     trial;
	logic              fits;

	assign in_ready = !valid_q || out_ready;
	assign trial    = root_in + BIT_V;
	assign fits     = num_in >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			num_q  <= fits ? (num_in - trial) : num_in;
			root_q <= fits ? ((root_in >> 1) + BIT_V) : (root_in >> 1);
			side_q <= side_in;
		end
	end

	assign out_valid = valid_q;
	assign num_out   = num_q;
	assign root_out  = root_q;
	assign side_out  = side_q;

endmodule
